// File: rtl/iis_pkg.sv
// Shared constants and types for the integral image stream block.
package iis_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIM_W   = 11;
  localparam int PIX_W   = 8;
  localparam int CSUM_W  = 18;
  localparam int INTEG_W = 28;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef logic [APB_AW-3:0] reg_idx_t;
  localparam reg_idx_t REG_FRAME_WIDTH  = 1'b0;
  localparam reg_idx_t REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  // Scan position of the pixel about to be taken
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first_row;
    logic             first_col;
    logic             row_end;
    logic             frame_end;
  } iis_pos_t;

endpackage

// File: rtl/integral_image_stream_top.sv
// Top level: register port, scan counters, column-sum RAM and accumulator.
// A taken pixel is registered in the s1 stage and then in the output
// register; out_ready low can hold it. Throughput: one pixel per cycle
// unless out_ready stalls the output, set by the single column-sum RAM
// read-modify-write, whose back-to-back hazard is covered by forwarding.
// Reset (synchronous, rst_n low): counters and handshakes clear, frame width
// and height return to 1024; the column-sum RAM is not cleared.
module integral_image_stream_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [iis_pkg::APB_AW-1:0]   paddr,
  input  logic [iis_pkg::APB_DW-1:0]   pwdata,
  output logic [iis_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [iis_pkg::PIX_W-1:0]    in_pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [iis_pkg::INTEG_W-1:0]  out_integral_value,
  output logic                         out_row_end,
  output logic                         out_frame_end
);
  import iis_pkg::*;

  logic [DIM_W-1:0]  frame_width_r, frame_height_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;
  logic [DIM_W-1:0]  rd_val;
  iis_pos_t          pos;
  logic              take;
  logic              stage_ready;
  logic              ram_we;
  logic [COL_W-1:0]  ram_waddr;
  logic [CSUM_W-1:0] ram_wdata, ram_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_RESET;
      frame_height_r <= DIM_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  rd_val = frame_width_r;
      REG_FRAME_HEIGHT: rd_val = frame_height_r;
      default:          rd_val = '0;
    endcase
  end
  assign prdata = APB_DW'(rd_val);

  assign in_ready = stage_ready;
  assign take     = in_valid && stage_ready;

  iis_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (take),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .pos          (pos)
  );

  iis_ram #(
    .WIDTH (CSUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_colsum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (pos.col),
    .rdata (ram_rdata)
  );

  iis_accum u_accum (
    .clk                (clk),
    .rst_n              (rst_n),
    .take               (take),
    .pixel              (in_pixel),
    .pos                (pos),
    .stage_ready        (stage_ready),
    .ram_rdata          (ram_rdata),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_integral_value (out_integral_value),
    .out_row_end        (out_row_end),
    .out_frame_end      (out_frame_end)
  );

endmodule

// File: rtl/iis_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module iis_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/iis_scan.sv
// Column and row counters that mark row and frame ends.
module iis_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic [iis_pkg::DIM_W-1:0] frame_width,
  input  logic [iis_pkg::DIM_W-1:0] frame_height,
  output iis_pkg::iis_pos_t         pos
);
  import iis_pkg::*;

  localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             rend, fend;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (frame_width > MAX_W_D) begin
      w_eff = MAX_W_D;
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (frame_height > MAX_H_D) begin
      h_eff = MAX_H_D;
    end else begin
      h_eff = frame_height;
    end
  end

  assign col_inc = {1'b0, col_r} + (COL_W+1)'(1);
  assign row_inc = {1'b0, row_r} + (ROW_W+1)'(1);
  assign rend    = 32'(col_inc) >= 32'(w_eff);
  assign fend    = rend && (32'(row_inc) >= 32'(h_eff));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (rend) begin
        col_nxt = '0;
        row_nxt = fend ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign pos.col       = col_r;
  assign pos.first_row = (row_r == '0);
  assign pos.first_col = (col_r == '0);
  assign pos.row_end   = rend;
  assign pos.frame_end = fend;

endmodule

// File: rtl/iis_accum.sv
// Column-sum update, row accumulation and output register.
module iis_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [iis_pkg::PIX_W-1:0]   pixel,
  input  iis_pkg::iis_pos_t           pos,
  output logic                        stage_ready,
  input  logic [iis_pkg::CSUM_W-1:0]  ram_rdata,
  output logic                        ram_we,
  output logic [iis_pkg::COL_W-1:0]   ram_waddr,
  output logic [iis_pkg::CSUM_W-1:0]  ram_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [iis_pkg::INTEG_W-1:0] out_integral_value,
  output logic                        out_row_end,
  output logic                        out_frame_end
);
  import iis_pkg::*;

  logic                s1_v_r, s1_v_nxt;
  iis_pos_t            s1_pos_r;
  logic [PIX_W-1:0]    s1_pix_r;
  logic                fwd_r;
  logic [CSUM_W-1:0]   fwd_data_r;
  logic [INTEG_W-1:0]  left_r;
  logic                out_v_r, out_v_nxt;
  logic [INTEG_W-1:0]  out_integ_r;
  logic                out_rend_r, out_fend_r;
  logic                s1_adv;
  logic [CSUM_W-1:0]   base, csum;
  logic [INTEG_W-1:0]  integ;

  assign s1_adv      = s1_v_r && (!out_v_r || out_ready);
  assign stage_ready = !s1_v_r || s1_adv;

  // Take the column sum just written when the RAM read raced it
  always_comb begin
    if (s1_pos_r.first_row) begin
      base = '0;
    end else if (fwd_r) begin
      base = fwd_data_r;
    end else begin
      base = ram_rdata;
    end
    csum  = base + CSUM_W'(s1_pix_r);
    integ = s1_pos_r.first_col ? INTEG_W'(csum) : left_r + INTEG_W'(csum);
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pos_r   <= pos;
      s1_pix_r   <= pixel;
      fwd_r      <= s1_adv && (s1_pos_r.col == pos.col);
      fwd_data_r <= csum;
    end
    if (s1_adv) begin
      left_r      <= integ;
      out_integ_r <= integ;
      out_rend_r  <= s1_pos_r.row_end;
      out_fend_r  <= s1_pos_r.frame_end;
    end
  end

  assign ram_we    = s1_adv;
  assign ram_waddr = s1_pos_r.col;
  assign ram_wdata = csum;

  assign out_valid          = out_v_r;
  assign out_integral_value = out_integ_r;
  assign out_row_end        = out_rend_r;
  assign out_frame_end      = out_fend_r;

endmodule

// File: rtl/iis_checker.sv
// Port-level checks for the integral image stream top, bound to it.
module iis_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         pready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [iis_pkg::INTEG_W-1:0]  out_integral_value,
  input logic                         out_row_end,
  input logic                         out_frame_end
);
  import iis_pkg::*;

  a_pready_high: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_integral_value)
      && $stable(out_row_end) && $stable(out_frame_end))
    else $error("stalled result changed");

  a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind integral_image_stream_top iis_checker u_iis_checker (.*);
